// ===== hw/rtl/lsf_pkg.sv =====
package lsf_pkg;

   localparam int LINE_STORE_DEF  = 64;
   localparam int PATTERN_MAX_DEF = 8;

   localparam int CSR_DATA_W = 64;
   localparam int PLEN_W     = 4;
   localparam int OQ_DEPTH   = 4;
   localparam int OQ_PTR_W   = 2;
   localparam int OQ_CNT_W   = 3;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   typedef enum logic {
      CSR_PATTERN_BYTES  = 1'b0,
      CSR_PATTERN_LENGTH = 1'b1
   } csr_idx_type;

   typedef enum logic {
      ACT_DATA = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_RUN  = 1'b1
   } bk_state_type;

endpackage

// ===== hw/rtl/lsf_front.sv =====
module lsf_front
   import lsf_pkg::*;
#(
   parameter int LINE_STORE  = LINE_STORE_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   localparam int LEN_W      = $clog2(LINE_STORE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  req_type               item,
   input  logic [CSR_DATA_W-1:0] pattern_bytes,
   input  logic [PLEN_W-1:0]     pattern_length,
   output logic                  wr_en,
   output logic                  wr_bank,
   output logic [LEN_W-1:0]      wr_idx,
   output logic [7:0]            wr_byte,
   output logic                  job_push,
   output logic                  job_bank,
   output logic [LEN_W-1:0]      job_len
);

   localparam int WIN_W = 8 * PATTERN_MAX;
   localparam int CMP_W = (LEN_W + 1 > PLEN_W) ? LEN_W + 1 : PLEN_W;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             found_ff, found_in;
   logic             zero_ff, zero_in;
   logic             bank_ff, bank_in;

   logic [PLEN_W-1:0] clip_len;
   logic [PLEN_W-1:0] eff_len;
   logic              eff_hit;
   logic [LEN_W:0]    len_inc;
   logic              zero_new;
   logic [WIN_W-1:0]  window_new;
   logic [WIN_W-1:0]  tail;
   logic              tail_ok;
   logic              match_now;
   logic              found_new;
   logic              is_end;
   logic              is_nl;
   logic              is_data;
   logic              cut;
   logic              judge;
   logic              match_judge;

   // clip the length, then end the pattern at its first zero byte
   always_comb begin
      clip_len = (pattern_length > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                         : pattern_length;
      eff_len  = clip_len;
      eff_hit  = 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (!eff_hit && (PLEN_W'(k) < clip_len) &&
             (pattern_bytes[8*k +: 8] == ZERO_BYTE)) begin
            eff_len = PLEN_W'(k);
            eff_hit = 1'b1;
         end
      end
   end

   always_comb begin
      is_end     = (item.action == ACT_END);
      is_nl      = !is_end && (item.data_byte == NEWLINE_BYTE);
      is_data    = !is_end && !is_nl;
      len_inc    = {1'b0, len_ff} + (LEN_W+1)'(1);
      zero_new   = zero_ff || (item.data_byte == ZERO_BYTE);
      window_new = {item.data_byte, window_ff[WIN_W-1:8]};
      // newest eff_len bytes sit at the top; bring them down to byte 0
      tail       = window_new >> (8 * (PATTERN_MAX - int'(eff_len)));
      tail_ok    = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if ((PLEN_W'(k) < eff_len) && (tail[8*k +: 8] != pattern_bytes[8*k +: 8])) begin
            tail_ok = 1'b0;
         end
      end
      match_now  = (eff_len != '0) && (CMP_W'(len_inc) >= CMP_W'(eff_len)) && tail_ok;
      found_new  = found_ff || (!zero_new && match_now);
      cut        = (len_inc >= (LEN_W+1)'(LINE_STORE - 1));
      judge      = item_valid && (is_end ? (len_ff != '0) : (is_nl || cut));
      match_judge = (is_data ? found_new : found_ff) || (eff_len == '0);
   end

   always_comb begin
      wr_en    = item_valid && is_data;
      wr_bank  = bank_ff;
      wr_idx   = len_ff;
      wr_byte  = item.data_byte;
      job_push = judge && match_judge;
      job_bank = bank_ff;
      job_len  = is_data ? len_inc[LEN_W-1:0] : len_ff;
   end

   always_comb begin
      len_in    = len_ff;
      window_in = window_ff;
      found_in  = found_ff;
      zero_in   = zero_ff;
      bank_in   = bank_ff ^ job_push;
      if (judge) begin
         len_in    = '0;
         window_in = '0;
         found_in  = 1'b0;
         zero_in   = 1'b0;
      end else if (item_valid && is_data) begin
         len_in  = len_inc[LEN_W-1:0];
         zero_in = zero_new;
         if (!zero_new) begin
            window_in = window_new;
            found_in  = found_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         window_ff <= '0;
         found_ff  <= 1'b0;
         zero_ff   <= 1'b0;
         bank_ff   <= 1'b0;
      end else begin
         len_ff    <= len_in;
         window_ff <= window_in;
         found_ff  <= found_in;
         zero_ff   <= zero_in;
         bank_ff   <= bank_in;
      end
   end

endmodule

// ===== hw/rtl/lsf_job_q.sv =====
module lsf_job_q
   import lsf_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             valid,
   output logic             full
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [WIDTH-1:0] slot_in [2];
   logic [1:0]       cnt_ff, cnt_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign valid = (cnt_ff != 2'd0);
   assign full  = (cnt_ff == 2'd2);

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_data;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

// ===== hw/rtl/lsf_back.sv =====
module lsf_back
   import lsf_pkg::*;
#(
   parameter int LINE_STORE = LINE_STORE_DEF,
   localparam int LEN_W     = $clog2(LINE_STORE)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic             wr_bank,
   input  logic [LEN_W-1:0] wr_idx,
   input  logic [7:0]       wr_byte,
   input  logic             job_valid,
   input  logic             job_bank,
   input  logic [LEN_W-1:0] job_len,
   output logic             job_pop,
   output rsp_type          rsp_item,
   output logic             rsp_empty,
   input  logic             rsp_pop
);

   localparam int MEM_DEPTH = 2 * (1 << LEN_W);

   logic [7:0]       mem [MEM_DEPTH];
   logic [7:0]       rd_data_ff;

   bk_state_type     state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             fly_ff, fly_in;
   logic             fly_nl_ff, fly_nl_in;

   rsp_type             oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;

   logic issue_ok;
   logic rd_issue;
   logic nl_issue;
   logic oq_push;
   logic oq_pop;
   rsp_type oq_word;

   // leave room for the word in flight so the queue never overflows
   assign issue_ok = ((oq_cnt_ff + OQ_CNT_W'(fly_ff)) < OQ_CNT_W'(OQ_DEPTH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (job_valid) state_in = BK_RUN;
         BK_RUN:  if (issue_ok && (idx_ff == job_len)) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rd_issue = 1'b0;
      nl_issue = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            rd_issue = 1'b0;
            nl_issue = 1'b0;
         end
         BK_RUN: begin
            rd_issue = issue_ok && (idx_ff != job_len);
            nl_issue = issue_ok && (idx_ff == job_len);
         end
         default: begin
            rd_issue = 1'b0;
            nl_issue = 1'b0;
         end
      endcase
   end

   assign job_pop = nl_issue;

   always_comb begin
      idx_in    = (state_ff == BK_IDLE) ? '0 : (idx_ff + LEN_W'(rd_issue));
      fly_in    = rd_issue || nl_issue;
      fly_nl_in = nl_issue;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_bank, wr_idx}] <= wr_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[{job_bank, idx_ff}];
      end
   end

   always_comb begin
      oq_word.out_byte = fly_nl_ff ? NEWLINE_BYTE : rd_data_ff;
      oq_word.last     = fly_nl_ff;
      oq_push          = fly_ff;
      oq_pop           = rsp_pop && (oq_cnt_ff != '0);
      oq_wr_in         = oq_wr_ff + OQ_PTR_W'(oq_push);
      oq_rd_in         = oq_rd_ff + OQ_PTR_W'(oq_pop);
      oq_cnt_in        = oq_cnt_ff + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_word;
      end
   end

   assign rsp_item  = oq_ff[oq_rd_ff];
   assign rsp_empty = (oq_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         idx_ff    <= '0;
         fly_ff    <= 1'b0;
         fly_nl_ff <= 1'b0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         fly_ff    <= fly_in;
         fly_nl_ff <= fly_nl_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

endmodule

// ===== hw/rtl/line_substring_filter_top.sv =====
// Fixed-string line filter.
// Input queue: present a word on req_item and raise req_push; the word is
// taken on a clock edge with req_push high and req_full low. A word is a
// data byte (action 0) or an end-of-input mark (action 1).
// Result queue: while rsp_empty is low, rsp_item holds the oldest byte of a
// matching line; raise rsp_pop to take it. last marks the closing newline.
// Config: write pattern_bytes (index 0) or pattern_length (index 1) with
// csr_valid; csr_ready is always high. Write only while the block is idle.
// Front end: takes one input word per cycle while req_full is low, writes
// line bytes into one of two line banks and tracks the pattern over a
// sliding byte window. At a newline, end of input or a full line it judges
// the line and, on a match, queues a job for the back end. Back end:
// replays a queued line one byte per cycle while the four-word result
// queue has room, then a closing newline. A line's first byte passes the
// job queue, back-end read register and result queue. req_full rises while
// two matched lines wait in the job queue; it clears once the back end has
// sent the older one. A stalled receiver fills the result queue, which
// stops the back end, which backs up the job queue and raises req_full.
// Reset clears all control state; the line banks need no clearing.
module line_substring_filter_top
   import lsf_pkg::*;
#(
   parameter int LINE_STORE  = LINE_STORE_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_item,
   output logic                  req_full,
   output rsp_type               rsp_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LEN_W = $clog2(LINE_STORE);
   localparam int JOB_W = LEN_W + 1;

   logic [CSR_DATA_W-1:0] pattern_ff, pattern_in;
   logic [PLEN_W-1:0]     plen_ff, plen_in;

   logic             item_valid;
   logic             wr_en;
   logic             wr_bank;
   logic [LEN_W-1:0] wr_idx;
   logic [7:0]       wr_byte;
   logic             job_push;
   logic             job_bank_new;
   logic [LEN_W-1:0] job_len_new;
   logic [JOB_W-1:0] job_head;
   logic             job_valid;
   logic             job_pop;
   logic             job_full;

   assign csr_ready = 1'b1;

   // hold the config registers unless written
   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  pattern_in = csr_data;
            CSR_PATTERN_LENGTH: plen_in    = csr_data[PLEN_W-1:0];
            default:            pattern_in = pattern_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
      end
   end

   // stall intake whenever both line banks hold work for the back end
   assign req_full   = job_full;
   assign item_valid = req_push && !req_full;

   lsf_front #(
      .LINE_STORE  (LINE_STORE),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (req_item),
      .pattern_bytes  (pattern_ff),
      .pattern_length (plen_ff),
      .wr_en          (wr_en),
      .wr_bank        (wr_bank),
      .wr_idx         (wr_idx),
      .wr_byte        (wr_byte),
      .job_push       (job_push),
      .job_bank       (job_bank_new),
      .job_len        (job_len_new)
   );

   lsf_job_q #(
      .WIDTH (JOB_W)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_bank_new, job_len_new}),
      .pop       (job_pop),
      .head      (job_head),
      .valid     (job_valid),
      .full      (job_full)
   );

   lsf_back #(
      .LINE_STORE (LINE_STORE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_bank   (wr_bank),
      .wr_idx    (wr_idx),
      .wr_byte   (wr_byte),
      .job_valid (job_valid),
      .job_bank  (job_head[LEN_W]),
      .job_len   (job_head[LEN_W-1:0]),
      .job_pop   (job_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ===== hw/rtl/lsf_checker.sv =====
module lsf_checker
   import lsf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input rsp_type rsp_item,
   input logic    rsp_empty,
   input logic    rsp_pop
);

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_item))
      else $error("result word changed while waiting");

   // reset empties both queues
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

   // only the closing word carries a newline byte
   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_item.last == (rsp_item.out_byte == NEWLINE_BYTE)))
      else $error("last flag and newline byte disagree");

   // intake stalls only after taking a word
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without an input word");

endmodule

bind line_substring_filter_top lsf_checker u_lsf_checker (.*);

// ===== tb/line_substring_filter_top_tb.sv =====
`timescale 1ns / 1ps

module line_substring_filter_top_tb;
   import lsf_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 12;
   // A line is cut once it holds this many bytes.
   localparam int LINE_CUT     = LINE_STORE_DEF - 1;
   // Quiet cycles after the last expected word: covers the lead of the back
   // end and its idle state between lines, with margin.
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   req_type               req_item;
   logic                  req_full;
   rsp_type               rsp_item;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   line_substring_filter_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------
   // Line filter predictor: own copy of the line, the match state and
   // the two pattern registers.
   // ------------------------------------------------------------------
   logic [7:0]  line_mem [LINE_STORE_DEF];
   int          line_len     = 0;
   logic [63:0] tail_window  = '0;   // last 8 line bytes, newest on top
   bit          pat_found    = 1'b0;
   bit          zero_in_line = 1'b0;
   logic [63:0] pat_bytes    = '0;
   logic [3:0]  pat_len      = '0;

   // Bytes of matching lines that the block still owes us, oldest first.
   rsp_type     expected_line_bytes [$];

   int          error_count = 0;
   int          words_sent  = 0;
   int          cycle_count = 0;

   // Idle control for the sender and the receiver.
   bit          tx_steady     = 1'b0;
   bit          rx_steady     = 1'b0;
   int          rx_gap        = 0;
   int          hold_left     = 0;
   int          hold_request  = 0;

   // Pattern length in force: saturate to the maximum, stop at a zero byte.
   function automatic int match_length();
      int n;
      n = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
      for (int k = 0; k < n; k++) begin
         if (pat_bytes[8*k +: 8] == ZERO_BYTE) return k;
      end
      return n;
   endfunction

   // Judge the current line: on a hit (or an empty pattern), queue its
   // bytes and a closing newline; then start a fresh line.
   task automatic close_line();
      if (pat_found || match_length() == 0) begin
         for (int k = 0; k < line_len; k++) begin
            expected_line_bytes.push_back(rsp_type'{out_byte: line_mem[k], last: 1'b0});
         end
         expected_line_bytes.push_back(rsp_type'{out_byte: NEWLINE_BYTE, last: 1'b1});
      end
      line_len     = 0;
      tail_window  = '0;
      pat_found    = 1'b0;
      zero_in_line = 1'b0;
   endtask

   task automatic predict_line_output(input req_type w);
      int          n;
      logic [63:0] mask;
      if (w.action == ACT_END) begin
         // End of input on an empty line emits nothing; the byte is ignored.
         if (line_len > 0) close_line();
         return;
      end
      if (w.data_byte == NEWLINE_BYTE) begin
         close_line();
         return;
      end
      if (line_len < LINE_CUT) line_mem[line_len] = w.data_byte;
      line_len++;
      // From the first zero byte on, bytes are emitted but not matched.
      if (w.data_byte == ZERO_BYTE) zero_in_line = 1'b1;
      if (!zero_in_line) begin
         tail_window = {w.data_byte, tail_window[63:8]};
         n = match_length();
         if (n > 0 && line_len >= n) begin
            mask = (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
            if ((tail_window >> (64 - 8 * n)) == (pat_bytes & mask)) pat_found = 1'b1;
         end
      end
      if (line_len >= LINE_CUT) close_line();
   endtask

   // ------------------------------------------------------------------
   // Clock, timeout and result checking
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** line_substring_filter_top: FAILED **");
         $finish;
      end
   end

   // Compare every popped word with the oldest expectation.
   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_line_bytes.size() == 0) begin
            $error("unexpected result word: out_byte %h last %b",
                   rsp_item.out_byte, rsp_item.last);
            error_count++;
         end else begin
            want = expected_line_bytes.pop_front();
            if (rsp_item.out_byte !== want.out_byte) begin
               $error("out_byte mismatch: expected %h, actual %h",
                      want.out_byte, rsp_item.out_byte);
               error_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last mismatch: expected %b, actual %b", want.last, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: pop with random stalls; honor a hold-off request by keeping
   // pop low for the requested number of cycles.
   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else if (rx_gap > 0) begin
            rsp_pop <= 1'b0;
            rx_gap--;
         end else begin
            rsp_pop <= 1'b1;
            rx_gap = rx_steady ? 0 : pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Offer one word, hold it until taken, predict it, then maybe idle.
   // Push stays high into the next call when no gap is drawn.
   task automatic send_word(input logic act, input logic [7:0] b);
      int gap;
      req_item <= req_type'{action: act, data_byte: b};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      predict_line_output(req_type'{action: act, data_byte: b});
      words_sent++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(ACT_DATA, s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_word(ACT_DATA, NEWLINE_BYTE);
   endtask

   function automatic logic [63:0] pack_text(input string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   // Drop push, let every expected word drain, then let the block settle.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_line_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both pattern registers back to back; only call while idle.
   // Junk in the upper data bits of the length write must be dropped.
   task automatic set_pattern(input logic [63:0] bytes, input logic [3:0] len);
      logic [63:0] len_word;
      len_word      = {$urandom, $urandom};
      len_word[3:0] = len;
      csr_index <= CSR_PATTERN_BYTES;
      csr_data  <= bytes;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      pat_bytes = bytes;
      csr_index <= CSR_PATTERN_LENGTH;
      csr_data  <= len_word;
      do @(posedge clock); while (!csr_ready);
      pat_len = len_word[3:0];
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset leaves an empty pattern: every line passes, an empty line gives
   // a lone newline, and end of input on an empty line gives nothing.
   task automatic test_reset_pattern();
      send_line("ab");
      send_word(ACT_DATA, NEWLINE_BYTE);
      send_word(ACT_END, 8'hFF);
      send_text("z");
      send_word(ACT_END, 8'h00);
   endtask

   task automatic test_substring_match();
      wait_idle();
      set_pattern(pack_text("ab"), 4'd2);
      send_line("xxaby");
      send_line("axb");
      send_word(ACT_DATA, NEWLINE_BYTE);   // empty line, pattern set: dropped
      send_text("cab");
      send_word(ACT_END, 8'h5A);           // pending hit flushed by end of input
      send_word(ACT_END, 8'hA5);           // nothing left: ignored
      send_line("ba");
   endtask

   // Length above the maximum saturates; pattern of all-ones bytes.
   task automatic test_length_saturation();
      wait_idle();
      set_pattern({64{1'b1}}, 4'hF);
      repeat (8) send_word(ACT_DATA, 8'hFF);
      send_word(ACT_DATA, NEWLINE_BYTE);
      repeat (7) send_word(ACT_DATA, 8'hFF);
      send_word(ACT_DATA, 8'h01);
      send_word(ACT_DATA, NEWLINE_BYTE);
   endtask

   // A zero byte inside the pattern shortens it, down to empty.
   task automatic test_zero_in_pattern();
      wait_idle();
      set_pattern(64'h0000_0063_6363_0061, 4'd5);   // in force: "a"
      send_line("bab");
      send_line("ccc");
      wait_idle();
      set_pattern(64'h0000_0000_6262_6200, 4'd3);   // first byte zero: empty
      send_line("q");
      send_word(ACT_DATA, NEWLINE_BYTE);
   endtask

   // Bytes after a zero in the line are emitted but never matched.
   task automatic test_zero_in_line();
      wait_idle();
      set_pattern(pack_text("cd"), 4'd2);
      send_text("ab");
      send_word(ACT_DATA, ZERO_BYTE);
      send_line("cd");
      send_text("cd");
      send_word(ACT_DATA, ZERO_BYTE);
      send_line("x");
   endtask

   // Bytes match against the pattern in force when they arrive; the
   // empty-pattern test uses the pattern in force at the judgement.
   task automatic test_pattern_change_mid_line();
      wait_idle();
      set_pattern(pack_text("xy"), 4'd2);
      send_text("qx");
      wait_idle();
      set_pattern(pack_text("yz"), 4'd2);
      send_line("y");
      wait_idle();
      set_pattern(pack_text("ab"), 4'd2);
      send_text("ab");
      wait_idle();
      set_pattern(pack_text("zz"), 4'd2);
      send_line("k");
      wait_idle();
      set_pattern(pack_text("ab"), 4'd2);
      send_text("k");
      wait_idle();
      set_pattern(pack_text("ab"), 4'd0);
      send_line("m");
   endtask

   // Full lines are cut and judged; the newline after a cut is an empty line.
   task automatic test_long_lines();
      wait_idle();
      set_pattern('0, 4'd0);
      for (int i = 0; i < LINE_CUT; i++) send_word(ACT_DATA, 8'h41 + 8'(i % 26));
      send_word(ACT_DATA, NEWLINE_BYTE);
      wait_idle();
      set_pattern(pack_text("zz"), 4'd2);
      // hit on the last two bytes before the cut; the "z" just past the cut
      // opens a new line and must not pair with the one before it
      for (int i = 0; i < 68; i++) begin
         send_word(ACT_DATA, (i >= LINE_CUT - 2 && i <= LINE_CUT) ? "z" : "a");
      end
      send_word(ACT_DATA, NEWLINE_BYTE);
   endtask

   // Stall the receiver for a long stretch while the sender keeps offering
   // short matching lines, so the result and job queues fill and push stalls.
   task automatic test_receiver_holdoff();
      wait_idle();
      set_pattern('0, 4'd0);
      tx_steady    = 1'b1;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 8; i++) begin
         send_word(ACT_DATA, 8'h61 + 8'($urandom_range(0, 25)));
         send_word(ACT_DATA, NEWLINE_BYTE);
      end
      tx_steady = 1'b0;
   endtask

   // One well-formed line: bytes mostly from the pattern's own alphabet, the
   // pattern planted in about half the lines, closed by newline or end.
   task automatic send_random_line();
      logic [7:0] line_q [$];
      logic [7:0] b;
      int         len;
      int         n;
      int         at;
      int         r;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)       b = ZERO_BYTE;
         else if (r < 8)  b = 8'($urandom_range(0, 255));
         else if (r < 70) b = pat_bytes[8 * $urandom_range(0, 7) +: 8];
         else             b = 8'h61 + 8'($urandom_range(0, 1));
         if (b == ZERO_BYTE && r >= 3) b = 8'h61;
         line_q.push_back(b);
      end
      n = match_length();
      if (n > 0 && len >= n && $urandom_range(0, 1) == 1) begin
         at = $urandom_range(0, len - n);
         for (int k = 0; k < n; k++) line_q[at + k] = pat_bytes[8*k +: 8];
      end
      foreach (line_q[i]) send_word(ACT_DATA, line_q[i]);
      if ($urandom_range(0, 9) < 8) send_word(ACT_DATA, NEWLINE_BYTE);
      else                          send_word(ACT_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_lines();
      logic [63:0] bytes;
      logic [3:0]  len;
      int          goal;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               bytes = pack_text("ab");
               len   = 4'd0;
            end
            1: begin
               bytes = {64{1'b1}};
               len   = 4'hF;
            end
            2: begin
               bytes = {$urandom, $urandom};
               len   = 4'($urandom_range(0, 15));
            end
            default: begin
               for (int k = 0; k < 8; k++) bytes[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 3));
               if ($urandom_range(0, 9) == 0) bytes[8 * $urandom_range(0, 7) +: 8] = ZERO_BYTE;
               len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(1, 8));
            end
         endcase
         set_pattern(bytes, len);
         // phase 3 runs with no idling on either side
         tx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
         rx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
         goal = words_sent + 3;
         while (words_sent < goal) begin
            if ($urandom_range(0, 9) < 7) send_random_line();
            else send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
         tx_steady = 1'b0;
         rx_steady = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_PATTERN_BYTES;
      csr_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_pattern();
      test_substring_match();
      test_length_saturation();
      test_zero_in_pattern();
      test_zero_in_line();
      test_pattern_change_mid_line();
      test_long_lines();
      test_receiver_holdoff();
      test_random_lines();

      wait_idle();
      if (error_count == 0) begin
         $display("** line_substring_filter_top: PASSED **");
      end else begin
         $display("** line_substring_filter_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_front.sv
hw/rtl/lsf_job_q.sv
hw/rtl/lsf_back.sv
hw/rtl/line_substring_filter_top.sv
hw/rtl/lsf_checker.sv
tb/line_substring_filter_top_tb.sv
